>>> design/eers_pkg.sv
package eers_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned LEN_W = 11;
    localparam int unsigned STOP_ADDR_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR_MARKER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_LENGTH = 2'd3;

    localparam logic [7:0] RST_START_MARKER = 8'd2;
    localparam logic [7:0] RST_SEPARATOR_MARKER = 8'd31;
    localparam logic [7:0] RST_STOP_MARKER = 8'd3;
    localparam logic [LEN_W-1:0] RST_MAX_RECORD_LENGTH = 11'd64;

    localparam logic [LEN_W-1:0] LEN_CAP = 11'd2047;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam logic [1:0] VERDICT_STOP = 2'd0;
    localparam logic [1:0] VERDICT_UNFORMATTED = 2'd1;
    localparam logic [1:0] VERDICT_ERROR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        logic [1:0]             verdict;
        logic [STOP_ADDR_W-1:0] stop_address;
    } t_out_word;

    typedef struct packed {
        logic [7:0]       start_marker;
        logic [7:0]       separator_marker;
        logic [7:0]       stop_marker;
        logic [LEN_W-1:0] max_record_length;
    } t_cfg;

    typedef struct packed {
        logic      hit;
        t_out_word word;
    } t_scan_res;

endpackage

>>> design/eers_scan.sv
module eers_scan #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  eers_pkg::t_in_word  i_word,
    input  eers_pkg::t_cfg      i_cfg,
    output eers_pkg::t_scan_res o_res
);

    localparam int unsigned AW = $clog2(STORE_BYTES);
    localparam int unsigned WW = (AW > eers_pkg::STOP_ADDR_W) ? AW : eers_pkg::STOP_ADDR_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    typedef enum logic [1:0] {
        PH_KEY,
        PH_VALUE,
        PH_DONE
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [AW-1:0]              r_pos, n_pos;
    logic [eers_pkg::LEN_W-1:0] r_len, n_len;
    logic [eers_pkg::LEN_W-1:0] len_inc;
    logic [WW-1:0]              addr_wide;
    logic [7:0]                 b;
    logic                       printable;
    logic                       too_long;
    logic                       is_start;
    logic                       is_stop;

    assign b         = i_word.data_byte;
    assign printable = (b >= eers_pkg::PRINT_LO) && (b <= eers_pkg::PRINT_HI);
    assign is_start  = (b == i_cfg.start_marker);
    assign is_stop   = (b == i_cfg.stop_marker);
    assign len_inc   = (r_len == eers_pkg::LEN_CAP) ? r_len : r_len + 1'b1;
    assign too_long  = (len_inc == eers_pkg::LEN_CAP) || (len_inc > i_cfg.max_record_length);
    assign addr_wide = WW'(r_pos);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        o_res   = '0;
        if (i_word.restart) begin
            n_pos = AW'(1);
            n_len = eers_pkg::LEN_W'(1);
            if (!is_start) begin
                o_res.hit          = 1'b1;
                o_res.word.verdict = eers_pkg::VERDICT_UNFORMATTED;
                n_phase            = PH_DONE;
            end else if (is_stop) begin
                o_res.hit          = 1'b1;
                o_res.word.verdict = eers_pkg::VERDICT_STOP;
                n_phase            = PH_DONE;
            end else begin
                n_phase = PH_KEY;
            end
        end else if (r_phase != PH_DONE) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == LAST_ADDR) begin
                o_res.hit          = 1'b1;
                o_res.word.verdict = eers_pkg::VERDICT_ERROR;
                n_phase            = PH_DONE;
            end else begin
                n_len = len_inc;
                case (r_phase)
                    PH_KEY: begin
                        if ((!printable && (b != i_cfg.separator_marker)) || too_long) begin
                            o_res.hit          = 1'b1;
                            o_res.word.verdict = eers_pkg::VERDICT_ERROR;
                            n_phase            = PH_DONE;
                        end else if (!printable) begin
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (too_long || (!printable && !is_start && !is_stop)) begin
                            o_res.hit          = 1'b1;
                            o_res.word.verdict = eers_pkg::VERDICT_ERROR;
                            n_phase            = PH_DONE;
                        end else if (printable) begin
                            n_phase = PH_VALUE;
                        end else if (is_stop) begin
                            o_res.hit               = 1'b1;
                            o_res.word.verdict      = eers_pkg::VERDICT_STOP;
                            o_res.word.stop_address = addr_wide[eers_pkg::STOP_ADDR_W-1:0];
                            n_phase                 = PH_DONE;
                        end else begin
                            n_len   = eers_pkg::LEN_W'(1);
                            n_phase = PH_KEY;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_pos   <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

endmodule

>>> design/eeprom_record_end_scanner.sv
// Record-chain end scanner. Feed the store's bytes in ascending address order, one word per
// cycle, with restart set on the byte at address 0. Each byte is checked by one registered
// pass against the scan state (phase, address, record length), so a new word is taken every
// cycle; the single verdict of a scan (stop marker and its address, unformatted store, or
// format error) appears in the output register the cycle after the byte that decides it.
// Words after a verdict and before the next restart are taken and dropped. The input stalls
// only while a verdict waits in the output register under stall. Marker and length registers are
// to be written through the config port only while the scanner is idle; the block does not enforce this.
module eeprom_record_end_scanner #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  eers_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output eers_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [eers_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [eers_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    eers_pkg::t_cfg      r_cfg;
    eers_pkg::t_scan_res scan_res;
    eers_pkg::t_out_word r_out;
    logic                r_out_valid;
    logic                accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    eers_scan #(
        .STORE_BYTES(STORE_BYTES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_word  (i_in_data),
        .i_cfg   (r_cfg),
        .o_res   (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker      <= eers_pkg::RST_START_MARKER;
            r_cfg.separator_marker  <= eers_pkg::RST_SEPARATOR_MARKER;
            r_cfg.stop_marker       <= eers_pkg::RST_STOP_MARKER;
            r_cfg.max_record_length <= eers_pkg::RST_MAX_RECORD_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                eers_pkg::CFG_START_MARKER:      r_cfg.start_marker <= i_cfg_data[7:0];
                eers_pkg::CFG_SEPARATOR_MARKER:  r_cfg.separator_marker <= i_cfg_data[7:0];
                eers_pkg::CFG_STOP_MARKER:       r_cfg.stop_marker <= i_cfg_data[7:0];
                eers_pkg::CFG_MAX_RECORD_LENGTH: r_cfg.max_record_length <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && scan_res.hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && scan_res.hit) begin
            r_out <= scan_res.word;
        end
    end

endmodule

>>> design/eers_checker.sv
module eers_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input eers_pkg::t_out_word                 o_out_data,
    input logic                                o_out_valid,
    input logic                                i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.verdict == eers_pkg::VERDICT_STOP
            || o_out_data.verdict == eers_pkg::VERDICT_UNFORMATTED
            || o_out_data.verdict == eers_pkg::VERDICT_ERROR)
        else $error("undefined verdict code");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.verdict != eers_pkg::VERDICT_STOP
            |-> o_out_data.stop_address == '0)
        else $error("nonzero address without stop verdict");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow full stalled output");

    a_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("verdict without an accepted word");

endmodule

bind eeprom_record_end_scanner eers_checker u_eers_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_data (o_out_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall)
);
